### rtl/core/dttf_pkg.sv
package dttf_pkg;

  localparam int unsigned MaxFlagsDefault  = 8;
  localparam int unsigned MaxPlacesDefault = 19;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  localparam logic [3:0] VALUE_BYTES_RST = 4'd4;

  typedef enum logic [2:0] {
    CFG_VALUE_BYTES    = 3'd0,
    CFG_HAS_SET_FLAG   = 3'd1,
    CFG_FLAG_LETTERS   = 3'd2,
    CFG_DECIMAL_PLACES = 3'd3,
    CFG_ALLOW_NEGATIVE = 3'd4
  } cfg_idx_e;

  typedef enum logic [3:0] {
    ERR_OK      = 4'd0,
    ERR_NOT_NUM = 4'd1,
    ERR_FLAGS   = 4'd2,
    ERR_NO_NUM  = 4'd3,
    ERR_OVF     = 4'd4,
    ERR_PLACES  = 4'd5,
    ERR_NEG     = 4'd6,
    ERR_WIDE    = 4'd7,
    ERR_SIZE    = 4'd8,
    ERR_EXTRA   = 4'd9
  } err_e;

  typedef enum logic [2:0] {
    PH_LEAD  = 3'd0,
    PH_PRE   = 3'd1,
    PH_SIGN  = 3'd2,
    PH_INT   = 3'd3,
    PH_FRAC  = 3'd4,
    PH_POST  = 3'd5,
    PH_TRAIL = 3'd6,
    PH_SKIP  = 3'd7
  } phase_e;

  typedef enum logic [1:0] {
    ST_RUN = 2'd0,
    ST_PAD = 2'd1,
    ST_FIN = 2'd2
  } ctl_state_e;

  typedef struct packed {
    logic [7:0] char_code;
    logic       last_char;
  } in_item_t;

  typedef struct packed {
    logic [63:0] value;
    logic [3:0]  error_code;
    logic        text_ended;
  } out_item_t;

  // controller -> datapath
  typedef struct packed {
    logic take_char;
    logic pad_step;
    logic finish;
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic field_end;
    logic pad_done;
  } dp_sts_t;

endpackage

### rtl/core/dttf_ctrl.sv
module dttf_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output dttf_pkg::dp_cmd_t cmd_o,
  input  dttf_pkg::dp_sts_t sts_i
);
  import dttf_pkg::*;

  ctl_state_e state_q, state_d;
  logic       out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_RUN;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    in_ready_o  = 1'b0;
    cmd_o       = '0;
    out_valid_d = out_valid_q & ~out_ready_i;
    case (state_q)
      ST_RUN: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.take_char = 1'b1;
          if (sts_i.field_end) state_d = ST_PAD;
        end
      end
      ST_PAD: begin
        if (sts_i.pad_done) state_d = ST_FIN;
        else cmd_o.pad_step = 1'b1;
      end
      ST_FIN: begin
        // output slot free (or freeing this cycle)
        if (!out_valid_q || out_ready_i) begin
          cmd_o.finish = 1'b1;
          out_valid_d  = 1'b1;
          state_d      = ST_RUN;
        end
      end
      default: state_d = ST_RUN;
    endcase
  end

  assign out_valid_o = out_valid_q;

endmodule

### rtl/core/dttf_datapath.sv
module dttf_datapath #(
  parameter int unsigned MAX_FLAGS  = dttf_pkg::MaxFlagsDefault,
  parameter int unsigned MAX_PLACES = dttf_pkg::MaxPlacesDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [2:0]          cfg_index_i,
  input  logic [63:0]         cfg_data_i,
  input  dttf_pkg::in_item_t  in_item_i,
  input  dttf_pkg::dp_cmd_t   cmd_i,
  output dttf_pkg::dp_sts_t   sts_o,
  output dttf_pkg::out_item_t out_item_o
);
  import dttf_pkg::*;

  localparam int unsigned PlW = (MAX_PLACES < 1) ? 1 : $clog2(MAX_PLACES + 1);

  // configuration
  logic [3:0]  vb_q;
  logic        hsf_q;
  logic [63:0] letters_q;
  logic [4:0]  places_q;
  logic        allow_neg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vb_q        <= VALUE_BYTES_RST;
      hsf_q       <= 1'b0;
      letters_q   <= '0;
      places_q    <= '0;
      allow_neg_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_VALUE_BYTES:    vb_q        <= cfg_data_i[3:0];
        CFG_HAS_SET_FLAG:   hsf_q       <= cfg_data_i[0];
        CFG_FLAG_LETTERS:   letters_q   <= cfg_data_i;
        CFG_DECIMAL_PLACES: places_q    <= cfg_data_i[4:0];
        CFG_ALLOW_NEGATIVE: allow_neg_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // field state
  phase_e               ph_q, ph_d;
  logic [63:0]          acc_q, acc_d;
  logic [MAX_FLAGS-1:0] fb_q, fb_d;
  logic                 neg_q, neg_d;
  logic [PlW-1:0]       pl_q, pl_d;
  err_e                 err_q, err_d;
  logic                 pad_ovf_q, pad_ovf_d;
  out_item_t            out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q      <= PH_LEAD;
      acc_q     <= '0;
      fb_q      <= '0;
      neg_q     <= 1'b0;
      pl_q      <= '0;
      err_q     <= ERR_OK;
      pad_ovf_q <= 1'b0;
    end else begin
      ph_q      <= ph_d;
      acc_q     <= acc_d;
      fb_q      <= fb_d;
      neg_q     <= neg_d;
      pl_q      <= pl_d;
      err_q     <= err_d;
      pad_ovf_q <= pad_ovf_d;
    end
  end

  logic [7:0] c;
  logic       is_dig;
  assign c      = in_item_i.char_code;
  assign is_dig = (c >= CH_ZERO) && (c <= CH_NINE);

  // a new field starts from cleared state
  logic                 in_lead;
  logic [MAX_FLAGS-1:0] fb_eff;
  logic [63:0]          acc_eff;
  assign in_lead = (ph_q == PH_LEAD);
  assign fb_eff  = in_lead ? '0 : fb_q;
  assign acc_eff = in_lead ? '0 : acc_q;

  // flag letter match and letter count
  logic [MAX_FLAGS-1:0] hit;
  logic                 found;
  logic [3:0]           lc;
  always_comb begin
    int         k;
    logic       stop;
    logic [7:0] b;
    hit   = '0;
    found = 1'b0;
    k     = 0;
    stop  = 1'b0;
    for (int j = 0; j < MAX_FLAGS; j++) begin
      b = letters_q[8*j +: 8];
      if (!stop) begin
        if (b == 8'h00) begin
          stop = 1'b1;
        end else if (b != CH_SPACE) begin
          if (!found && b == c && !fb_eff[k]) begin
            hit[k] = 1'b1;
            found  = 1'b1;
          end
          k++;
        end
      end
    end
    lc = 4'(k);
  end

  logic signed [8:0] nb;
  assign nb = $signed({2'b00, vb_q, 3'b000}) - $signed({8'd0, hsf_q})
            - $signed({5'd0, lc});

  logic [PlW-1:0] pl_sat;
  assign pl_sat = (places_q > 5'(MAX_PLACES)) ? PlW'(MAX_PLACES) : places_q[PlW-1:0];

  // times ten plus digit, with exact overflow
  logic [63:0] mul_in;
  logic [3:0]  mul_d;
  logic [67:0] prod;
  logic        ovf;
  assign mul_in = cmd_i.pad_step ? acc_q : acc_eff;
  assign mul_d  = cmd_i.pad_step ? 4'd0 : c[3:0];
  assign prod   = ({4'd0, mul_in} << 3) + ({4'd0, mul_in} << 1) + {64'd0, mul_d};
  assign ovf    = |prod[67:64];

  always_comb begin
    logic pre, nstart, integ, after, add;
    ph_d      = ph_q;
    acc_d     = acc_q;
    fb_d      = fb_q;
    neg_d     = neg_q;
    pl_d      = pl_q;
    err_d     = err_q;
    pad_ovf_d = pad_ovf_q;
    pre       = 1'b0;
    nstart    = 1'b0;
    integ     = 1'b0;
    after     = 1'b0;
    add       = 1'b0;
    if (cmd_i.take_char && c != CH_COMMA) begin
      case (ph_q)
        PH_LEAD: begin
          if (c != CH_SPACE) begin
            acc_d = '0;
            fb_d  = '0;
            neg_d = 1'b0;
            err_d = ERR_OK;
            pl_d  = pl_sat;
            if (nb < 0) begin
              err_d = ERR_FLAGS;
              ph_d  = PH_SKIP;
            end else begin
              pre = 1'b1;
            end
          end
        end
        PH_PRE:  pre = 1'b1;
        PH_SIGN: nstart = 1'b1;
        PH_INT:  integ = 1'b1;
        PH_FRAC: begin
          if (is_dig) begin
            if (pl_q != '0) begin
              add  = 1'b1;
              pl_d = pl_q - 1'b1;
            end else begin
              err_d = ERR_PLACES;
              ph_d  = PH_SKIP;
            end
          end else begin
            after = 1'b1;
          end
        end
        PH_POST: after = 1'b1;
        PH_TRAIL: begin
          if (c != CH_SPACE) begin
            err_d = ERR_EXTRA;
            ph_d  = PH_SKIP;
          end
        end
        default: ;
      endcase
      if (pre) begin
        if (found) begin
          fb_d = fb_eff | hit;
          ph_d = PH_PRE;
        end else if (c == CH_MINUS) begin
          neg_d = 1'b1;
          ph_d  = PH_SIGN;
        end else begin
          nstart = 1'b1;
        end
      end
      if (nstart) begin
        if (nb > 0 && !is_dig) begin
          err_d = ERR_NO_NUM;
          ph_d  = PH_SKIP;
        end else begin
          integ = 1'b1;
        end
      end
      if (integ) begin
        ph_d = PH_INT;
        if (is_dig) add = 1'b1;
        else if (c == CH_DOT && places_q != 5'd0) ph_d = PH_FRAC;
        else after = 1'b1;
      end
      if (after) begin
        if (found) begin
          fb_d = fb_eff | hit;
          ph_d = PH_POST;
        end else if (c == CH_SPACE) begin
          ph_d = PH_TRAIL;
        end else begin
          err_d = ERR_EXTRA;
          ph_d  = PH_SKIP;
        end
      end
      if (add) begin
        if (ovf) begin
          err_d = ERR_OVF;
          ph_d  = PH_SKIP;
        end else begin
          acc_d = prod[63:0];
        end
      end
    end else if (cmd_i.pad_step) begin
      if (ovf) begin
        pad_ovf_d = 1'b1;
      end else begin
        acc_d = prod[63:0];
        pl_d  = pl_q - 1'b1;
      end
    end else if (cmd_i.finish) begin
      ph_d      = PH_LEAD;
      acc_d     = '0;
      fb_d      = '0;
      neg_d     = 1'b0;
      pl_d      = '0;
      err_d     = ERR_OK;
      pad_ovf_d = 1'b0;
    end
  end

  assign sts_o.field_end = (c == CH_COMMA) || in_item_i.last_char;
  assign sts_o.pad_done  = (pl_q == '0) || pad_ovf_q;

  // result assembly
  logic [MAX_FLAGS-1:0]    fb_rev;
  logic [63+MAX_FLAGS:0]   fl_sh;
  logic [63:0]             nb_mask, w_mask, marker, sval, val_f;
  logic [6:0]              wbits;
  err_e                    err_f;

  always_comb begin
    for (int k = 0; k < MAX_FLAGS; k++) fb_rev[MAX_FLAGS-1-k] = fb_q[k];
  end

  assign wbits   = {vb_q, 3'b000};
  assign fl_sh   = (64 + MAX_FLAGS)'(fb_rev) << (wbits - {6'd0, hsf_q});
  assign nb_mask = (64'd1 << nb[5:0]) - 64'd1;
  assign w_mask  = (64'd1 << wbits[5:0]) - 64'd1;
  assign marker  = hsf_q ? (64'd1 << 6'(wbits - 7'd1)) : 64'd0;
  assign sval    = neg_q ? (64'd0 - acc_q) : acc_q;

  always_comb begin
    err_f = ERR_OK;
    val_f = '0;
    if (vb_q == 4'd0) begin
      err_f = ERR_NOT_NUM;
    end else if (ph_q == PH_LEAD) begin
      err_f = ERR_OK;
    end else if (err_q inside {[ERR_FLAGS:ERR_PLACES]}) begin
      err_f = err_q;
    end else if (nb < 0) begin
      err_f = ERR_FLAGS;
    end else if ((ph_q == PH_PRE || ph_q == PH_SIGN) && nb > 0) begin
      err_f = ERR_NO_NUM;
    end else if (pad_ovf_q) begin
      err_f = ERR_OVF;
    end else if (neg_q && !allow_neg_q) begin
      err_f = ERR_NEG;
    end else if (nb < 64 && (acc_q & ~nb_mask) != 64'd0) begin
      err_f = ERR_WIDE;
    end else if (!(vb_q inside {4'd1, 4'd2, 4'd4, 4'd8})) begin
      err_f = ERR_SIZE;
    end else if (err_q == ERR_EXTRA) begin
      err_f = ERR_EXTRA;
    end else begin
      val_f = sval;
      if (nb < 64) val_f = (sval & nb_mask) | marker | fl_sh[63+MAX_FLAGS:MAX_FLAGS];
      if (vb_q != 4'd8) val_f = val_f & w_mask;
    end
  end

  logic text_end_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.take_char) text_end_q <= in_item_i.last_char;
    if (cmd_i.finish) begin
      out_q.value      <= val_f;
      out_q.error_code <= err_f;
      out_q.text_ended <= text_end_q;
    end
  end

  assign out_item_o = out_q;

endmodule

### rtl/core/decimal_text_to_fixed_parser_unit.sv
// Channel   Direction  Handshake                Payload
// in        input      in_valid_i / in_ready_o  in_item_i  (char_code, last_char)
// out       output     out_valid_o / out_ready_i out_item_o (value, error_code, text_ended)
// cfg       input      cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
// Flow: a character inside a field is one transfer per cycle. A comma or a
// last-marked character is taken, then one multiply-by-ten step follows per
// missing fraction digit (0..MAX_PLACES), then a check step and a finish step.
// The pad loop runs through the shared times-ten adder.
// Stalls: a held result sits in the output register; characters keep flowing
// until the next field end, which waits in the finish step for the slot.
// Reset: asynchronous, active low; clears config to defaults and field state.
// cfg is always ready.
module decimal_text_to_fixed_parser_unit #(
  parameter int unsigned MAX_FLAGS  = dttf_pkg::MaxFlagsDefault,
  parameter int unsigned MAX_PLACES = dttf_pkg::MaxPlacesDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  dttf_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output dttf_pkg::out_item_t out_item_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [2:0]          cfg_index_i,
  input  logic [63:0]         cfg_data_i
);
  import dttf_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  // config writes land directly in the register bank
  assign cfg_ready_o = 1'b1;

  dttf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .cmd_o      (cmd),
    .sts_i      (sts)
  );

  dttf_datapath #(
    .MAX_FLAGS (MAX_FLAGS),
    .MAX_PLACES(MAX_PLACES)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_valid_i & cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .in_item_i  (in_item_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .out_item_o (out_item_o)
  );

  // a field end pauses intake for the pad/finish steps
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o &&
     (in_item_i.char_code == CH_COMMA || in_item_i.last_char)) |=> !in_ready_o)
    else $error("intake not paused after field end");

  // failed fields deliver zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_item_o.error_code != ERR_OK) |-> out_item_o.value == 64'd0)
    else $error("nonzero value with error");

  // a newly valid result has a code in the defined range
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> out_item_o.error_code <= ERR_EXTRA)
    else $error("error code out of range");

endmodule

### tb/sv/dttf_checker.sv
`timescale 1ns / 1ps

module dttf_checker (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_ready_i,
  input  dttf_pkg::in_item_t  in_item_i,
  input  logic                out_valid_i,
  input  logic                out_ready_i,
  input  dttf_pkg::out_item_t out_item_i,
  input  logic                cfg_valid_i,
  input  logic                cfg_ready_i,
  input  logic [2:0]          cfg_index_i,
  input  logic [63:0]         cfg_data_i,
  output int unsigned         fail_count_o,
  output int unsigned         pending_o
);
  import dttf_pkg::*;

  // shadow configuration
  logic [3:0]  width_bytes;
  logic        marker_en;
  logic [63:0] letters;
  logic [4:0]  places_cfg;
  logic        neg_en;

  // shadow field state
  phase_e      ph;
  logic [63:0] acc;
  logic [7:0]  seen;
  logic        is_neg;
  int          places_rem;
  err_e        held_err;

  out_item_t   field_results[$];

  function automatic int count_letters();
    int n;
    n = 0;
    for (int j = 0; j < 8; j++) begin
      if (letters[8*j +: 8] == 8'h00) break;
      if (letters[8*j +: 8] != CH_SPACE) n++;
    end
    return n;
  endfunction

  function automatic int free_bits();
    return int'(width_bytes) * 8 - int'(marker_en) - count_letters();
  endfunction

  function automatic bit claim_letter(logic [7:0] c);
    int k;
    k = 0;
    for (int j = 0; j < 8; j++) begin
      if (letters[8*j +: 8] == 8'h00) break;
      if (letters[8*j +: 8] == CH_SPACE) continue;
      if (letters[8*j +: 8] == c && !seen[k]) begin
        seen[k] = 1'b1;
        return 1'b1;
      end
      k++;
    end
    return 1'b0;
  endfunction

  function automatic bit is_dec(logic [7:0] c);
    return c >= CH_ZERO && c <= CH_NINE;
  endfunction

  function automatic void abort_field(err_e e);
    held_err = e;
    ph = PH_SKIP;
  endfunction

  // exact 64-bit overflow check of acc*10+d
  function automatic bit times_ten_add(int unsigned d);
    logic [63:0] lim;
    lim = (64'hFFFF_FFFF_FFFF_FFFF - 64'(d)) / 64'd10;
    if (acc > lim) return 1'b0;
    acc = acc * 64'd10 + 64'(d);
    return 1'b1;
  endfunction

  function automatic void push_digit(logic [7:0] c);
    if (!times_ten_add(int'(c - CH_ZERO))) abort_field(ERR_OVF);
  endfunction

  function automatic void tail_char(logic [7:0] c);
    if (claim_letter(c)) ph = PH_POST;
    else if (c == CH_SPACE) ph = PH_TRAIL;
    else abort_field(ERR_EXTRA);
  endfunction

  function automatic void int_char(logic [7:0] c);
    ph = PH_INT;
    if (is_dec(c)) push_digit(c);
    else if (c == CH_DOT && places_cfg != 0) ph = PH_FRAC;
    else tail_char(c);
  endfunction

  function automatic void first_num_char(logic [7:0] c);
    if (free_bits() > 0 && !is_dec(c)) abort_field(ERR_NO_NUM);
    else int_char(c);
  endfunction

  function automatic void field_char(logic [7:0] c);
    if (ph == PH_LEAD) begin
      if (c == CH_SPACE) return;
      acc = '0;
      seen = '0;
      is_neg = 1'b0;
      held_err = ERR_OK;
      places_rem = (places_cfg > 19) ? 19 : int'(places_cfg);
      if (free_bits() < 0) begin
        abort_field(ERR_FLAGS);
        return;
      end
      ph = PH_PRE;
    end
    case (ph)
      PH_PRE: begin
        if (claim_letter(c)) return;
        if (c == CH_MINUS) begin
          is_neg = 1'b1;
          ph = PH_SIGN;
          return;
        end
        first_num_char(c);
      end
      PH_SIGN: first_num_char(c);
      PH_INT: int_char(c);
      PH_FRAC: begin
        if (is_dec(c)) begin
          if (places_rem > 0) begin
            push_digit(c);
            places_rem--;
          end else begin
            abort_field(ERR_PLACES);
          end
        end else begin
          tail_char(c);
        end
      end
      PH_POST: tail_char(c);
      PH_TRAIL: if (c != CH_SPACE) abort_field(ERR_EXTRA);
      default: ;
    endcase
  endfunction

  function automatic err_e close_field(output logic [63:0] v);
    int nb, w, top;
    logic [63:0] f, r;
    v = '0;
    if (width_bytes == 0) return ERR_NOT_NUM;
    if (ph == PH_LEAD) return ERR_OK;
    if (held_err inside {ERR_FLAGS, ERR_NO_NUM, ERR_OVF, ERR_PLACES}) return held_err;
    nb = free_bits();
    if (nb < 0) return ERR_FLAGS;
    if ((ph == PH_PRE || ph == PH_SIGN) && nb > 0) return ERR_NO_NUM;
    while (places_rem > 0) begin
      if (!times_ten_add(0)) return ERR_OVF;
      places_rem--;
    end
    if (is_neg && !neg_en) return ERR_NEG;
    if (nb < 64 && acc >= (64'd1 << nb)) return ERR_WIDE;
    if (!(width_bytes inside {4'd1, 4'd2, 4'd4, 4'd8})) return ERR_SIZE;
    if (held_err == ERR_EXTRA) return ERR_EXTRA;
    w = int'(width_bytes) * 8;
    r = is_neg ? (64'd0 - acc) : acc;
    if (nb < 64) begin
      f = '0;
      if (marker_en) f[w-1] = 1'b1;
      top = w - int'(marker_en) - 1;
      for (int k = 0; k < 8; k++)
        if (seen[k] && top - k >= 0) f[top-k] = 1'b1;
      r = (r & ((64'd1 << nb) - 64'd1)) | f;
    end
    if (w < 64) r &= (64'd1 << w) - 64'd1;
    v = r;
    return ERR_OK;
  endfunction

  function automatic void clear_field();
    ph = PH_LEAD;
    acc = '0;
    seen = '0;
    is_neg = 1'b0;
    places_rem = 0;
    held_err = ERR_OK;
  endfunction

  assign pending_o = field_results.size();

  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t exp_r, got;
    logic [63:0] v;
    err_e e;
    int unsigned errs;
    errs = 0;
    if (!rst_ni) begin
      width_bytes = VALUE_BYTES_RST;
      marker_en = 1'b0;
      letters = '0;
      places_cfg = '0;
      neg_en = 1'b0;
      clear_field();
      field_results.delete();
      fail_count_o <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        got = out_item_i;
        if (field_results.size() == 0) begin
          $error("unexpected result value=%h err=%0d", got.value, got.error_code);
          errs++;
        end else begin
          exp_r = field_results.pop_front();
          if (got.value !== exp_r.value) begin
            $error("value: expected %h actual %h", exp_r.value, got.value);
            errs++;
          end
          if (got.error_code !== exp_r.error_code) begin
            $error("error_code: expected %0d actual %0d", exp_r.error_code, got.error_code);
            errs++;
          end
          if (got.text_ended !== exp_r.text_ended) begin
            $error("text_ended: expected %0b actual %0b", exp_r.text_ended, got.text_ended);
            errs++;
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        if (in_item_i.char_code != CH_COMMA) field_char(in_item_i.char_code);
        if (in_item_i.char_code == CH_COMMA || in_item_i.last_char) begin
          e = close_field(v);
          exp_r.value = v;
          exp_r.error_code = e;
          exp_r.text_ended = in_item_i.last_char;
          field_results.push_back(exp_r);
          clear_field();
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_idx_e'(cfg_index_i))
          CFG_VALUE_BYTES:    width_bytes = cfg_data_i[3:0];
          CFG_HAS_SET_FLAG:   marker_en = cfg_data_i[0];
          CFG_FLAG_LETTERS:   letters = cfg_data_i;
          CFG_DECIMAL_PLACES: places_cfg = cfg_data_i[4:0];
          CFG_ALLOW_NEGATIVE: neg_en = cfg_data_i[0];
          default: ;
        endcase
      end
      if (errs != 0) fail_count_o <= fail_count_o + errs;
    end
  end
endmodule

### tb/sv/tb_top.sv
`timescale 1ns / 1ps

// Parser testbench top: drives characters and config, stalls the result side,
// and reports the verdict. All prediction and comparison lives in dttf_checker.
module tb_top;
  import dttf_pkg::*;

  localparam int unsigned WatchdogLimit = 2000;
  localparam int unsigned RandomChars   = 1100;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  in_item_t    in_item;
  logic        out_valid;
  logic        out_ready;
  out_item_t   out_item;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [63:0] cfg_data;
  int unsigned fail_count;
  int unsigned pending;
  int unsigned idle_cycles;
  bit          stim_done;

  decimal_text_to_fixed_parser_unit i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_item_o  (out_item),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  dttf_checker i_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .in_item_i    (in_item),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .out_item_i   (out_item),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_i  (cfg_ready),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // One character transfer. Gap drawn per item; valid then held until accepted.
  // Valid stays up after the transfer; the next gap or a pause drops it.
  task automatic send_char(logic [7:0] c, logic last);
    int unsigned gap;
    gap = $urandom_range(0, 13);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_item.char_code <= c;
    in_item.last_char <= last;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic send_text(string s, bit mark_last);
    for (int i = 0; i < s.len(); i++)
      send_char(s[i], mark_last && (i == s.len() - 1));
  endtask

  // Config writes only while idle: drain results, then allow for the pad loop.
  task automatic write_reg(cfg_idx_e idx, logic [63:0] d);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (30) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_all(logic [3:0] nbytes, logic mark, logic [63:0] lets,
                         logic [4:0] plc, logic neg);
    write_reg(CFG_VALUE_BYTES, 64'(nbytes));
    write_reg(CFG_HAS_SET_FLAG, 64'(mark));
    write_reg(CFG_FLAG_LETTERS, lets);
    write_reg(CFG_DECIMAL_PLACES, 64'(plc));
    write_reg(CFG_ALLOW_NEGATIVE, 64'(neg));
  endtask

  // Mostly well-formed field chars with random content; some raw noise.
  function automatic logic [7:0] pick_char(logic [63:0] lets);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 45) return 8'h30 + 8'($urandom_range(0, 9));
    if (r < 55) return CH_COMMA;
    if (r < 63) return CH_SPACE;
    if (r < 68) return CH_DOT;
    if (r < 73) return CH_MINUS;
    if (r < 85) return lets[8*$urandom_range(0, 7) +: 8];
    return 8'($urandom_range(0, 255));
  endfunction

  // Result side: random wait before taking each result.
  always begin : out_side
    int unsigned gap;
    gap = $urandom_range(0, 13);
    if (gap != 0) begin
      out_ready <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    out_ready <= 1'b1;
    do @(posedge clk); while (!(out_valid && rst_n));
    @(negedge clk);
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchdogLimit && !stim_done) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  initial begin
    logic [63:0] lets;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_item = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    stim_done = 1'b0;
    repeat (4) @(negedge clk);
    rst_n = 1'b1;

    // directed: reset config first, then flags, fraction, signs, errors
    send_text("12, 4294967295,4294967296, ,", 1'b0);
    send_text("-5", 1'b1);
    set_all(4'd1, 1'b1, 64'h0000_0000_0041_2042, 5'd2, 1'b1);
    send_text("AB-1.5B,A.,", 1'b0);
    send_text("1.234,AAA,x,", 1'b1);
    set_all(4'd8, 1'b0, 64'h0, 5'd19, 1'b0);
    send_text("18446744073709551616,1.5,-1,", 1'b0);
    send_char(8'hFF, 1'b1);
    set_all(4'd0, 1'b0, 64'h0, 5'd0, 1'b0);
    send_text("7,", 1'b1);
    set_all(4'd3, 1'b0, 64'h0, 5'd31, 1'b1);
    send_text("9", 1'b1);
    set_all(4'd15, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF, 5'd0, 1'b0);
    send_text("1", 1'b1);

    // random phases over several settings
    for (int ph = 0; ph < 11; ph++) begin
      lets = {$urandom, $urandom};
      for (int j = 0; j < 8; j++)
        if ($urandom_range(0, 4) == 0) lets[8*j +: 8] = CH_SPACE;
      if (ph % 3 == 0) lets = 64'h0;
      if (ph % 3 == 1) lets[8*$urandom_range(1, 7) +: 8] = 8'h00;
      set_all(ph == 0 ? 4'd8 : (ph == 1 ? 4'd0 : 4'(1 << $urandom_range(0, 3))),
              1'($urandom), lets, ph == 2 ? 5'd19 : 5'($urandom_range(0, 31)),
              1'($urandom));
      for (int i = 0; i < RandomChars / 11; i++) begin
        send_char(pick_char(lets), $urandom_range(0, 40) == 0);
      end
      if (ph == 5) begin
        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        @(negedge clk);
      end
    end
    send_char(CH_COMMA, 1'b1);
    in_valid <= 1'b0;

    while (pending != 0) @(negedge clk);
    stim_done = 1'b1;
    repeat (40) @(negedge clk);
    if (fail_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule
